// File: rtl/core/psst_pkg.sv
package psst_pkg;

  localparam int SLOTS_DEF = 8;
  localparam int MAX_RES = 8;

  localparam logic [2:0] OP_UPSERT   = 3'd0;
  localparam logic [2:0] OP_REMOVE   = 3'd1;
  localparam logic [2:0] OP_CLEAR    = 3'd2;
  localparam logic [2:0] OP_ACCENT   = 3'd3;
  localparam logic [2:0] OP_PROGRESS = 3'd4;
  localparam logic [2:0] OP_SNAPSHOT = 3'd5;

  localparam logic [2:0] ST_OFFLINE = 3'd6;
  localparam logic [6:0] PROG_MAX = 7'd100;

  typedef struct packed {
    logic start;
    logic step;
    logic apply;
    logic emit_next;
  } psst_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic emit_done;
  } psst_sts_t;

  function automatic logic [2:0] prio(input logic [2:0] s);
    case (s)
      3'd3: prio = 3'd4;
      3'd2: prio = 3'd3;
      3'd5: prio = 3'd2;
      3'd1: prio = 3'd1;
      3'd4: prio = 3'd1;
      default: prio = 3'd0;
    endcase
  endfunction

endpackage

// File: rtl/core/priority_session_slot_table.sv
// channel  | handshake            | payload
// in       | in_valid / in_ready  | operation key status now_ms value limit
// out      | out_valid / out_ready| slot ... last
// one item: an accept state, a scan over all SLOTS slots, an update state,
// then one result per cycle while out_ready holds (snapshot gives up to 8);
// items do not overlap; the key and victim scan takes one slot per cycle
// reset clears all slots at once; out stalls hold the current result

module priority_session_slot_table
  import psst_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [31:0] key,
  input  logic [2:0]  status,
  input  logic [31:0] now_ms,
  input  logic [7:0]  value,
  input  logic [3:0]  limit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  slot,
  output logic        slot_valid,
  output logic [3:0]  used_count,
  output logic [2:0]  top_status,
  output logic [31:0] entry_key,
  output logic [2:0]  entry_status,
  output logic [31:0] entry_time,
  output logic        entry_has_accent,
  output logic [7:0]  entry_hue,
  output logic [6:0]  entry_progress,
  output logic        last
);

  psst_cmd_t cmd;
  psst_sts_t sts;

  psst_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .sts
  );

  psst_dp #(.SLOTS(SLOTS)) u_dp (
    .clk, .rst, .cmd, .sts, .operation, .key, .status, .now_ms, .value, .limit,
    .slot, .slot_valid, .used_count, .top_status, .entry_key, .entry_status,
    .entry_time, .entry_has_accent, .entry_hue, .entry_progress, .last
  );

endmodule

// File: rtl/core/psst_ctrl.sv
module psst_ctrl
  import psst_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output psst_cmd_t cmd,
  input  psst_sts_t sts
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_done) state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit_next = 1'b1;
          if (sts.emit_done) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while emitting");
  a_apply_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |=> out_valid) else $error("apply not followed by emit");
  a_start_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> cmd.step) else $error("start not followed by scan");

endmodule

// File: rtl/core/psst_dp.sv
module psst_dp
  import psst_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF,
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  logic        clk,
  input  logic        rst,
  input  psst_cmd_t   cmd,
  output psst_sts_t   sts,
  input  logic [2:0]  operation,
  input  logic [31:0] key,
  input  logic [2:0]  status,
  input  logic [31:0] now_ms,
  input  logic [7:0]  value,
  input  logic [3:0]  limit,
  output logic [2:0]  slot,
  output logic        slot_valid,
  output logic [3:0]  used_count,
  output logic [2:0]  top_status,
  output logic [31:0] entry_key,
  output logic [2:0]  entry_status,
  output logic [31:0] entry_time,
  output logic        entry_has_accent,
  output logic [7:0]  entry_hue,
  output logic [6:0]  entry_progress,
  output logic        last
);

  logic [SLOTS-1:0] used;
  logic [31:0] skey [SLOTS];
  logic [2:0]  sst [SLOTS];
  logic [31:0] stime [SLOTS];
  logic [SLOTS-1:0] sacc;
  logic [7:0]  shue [SLOTS];
  logic [6:0]  sprog [SLOTS];

  // captured request
  logic [2:0] r_op, r_st;
  logic [31:0] r_key, r_now;
  logic [7:0] r_val;
  logic [3:0] r_lim;

  // scan results
  logic [CW-1:0] idx;
  logic [IW-1:0] ix;
  logic hit_f, free_f, vic_f, top_f;
  logic [IW-1:0] hit_i, free_i, vic_i, top_i;
  logic [2:0] vic_p, top_p;

  // emit
  logic [CW-1:0] eidx;
  logic [3:0] ecnt;
  logic [CW-1:0] cnt;
  logic chosen_v;
  logic [IW-1:0] chosen;

  assign ix = idx[IW-1:0];
  assign sts.scan_done = (idx == CW'(SLOTS - 1));

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      r_op <= operation; r_key <= key; r_st <= status;
      r_now <= now_ms; r_val <= value;
      r_lim <= (limit > 4'(MAX_RES)) ? 4'(MAX_RES) : limit;
      idx <= '0;
      hit_f <= 1'b0; free_f <= 1'b0; vic_f <= 1'b0;
      hit_i <= '0; free_i <= '0; vic_i <= '0; vic_p <= '0;
    end else if (cmd.step) begin
      if (used[ix] && skey[ix] == r_key && !hit_f) begin
        hit_f <= 1'b1; hit_i <= ix;
      end
      if (!used[ix] && !free_f) begin
        free_f <= 1'b1; free_i <= ix;
      end
      if (!vic_f || prio(sst[ix]) < vic_p) begin
        vic_f <= 1'b1; vic_i <= ix; vic_p <= prio(sst[ix]);
      end
      if (!sts.scan_done) idx <= idx + 1'b1;
    end
  end

  // table update and result selection
  logic ins;
  logic [IW-1:0] ins_i;
  always_comb begin
    ins = 1'b0;
    ins_i = free_i;
    if (r_op == OP_UPSERT && r_st < ST_OFFLINE && !hit_f) begin
      if (free_f) ins = 1'b1;
      else if (prio(r_st) > vic_p) begin
        ins = 1'b1; ins_i = vic_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      sacc <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        skey[i] <= '0; sst[i] <= '0; stime[i] <= '0; shue[i] <= '0; sprog[i] <= '0;
      end
    end else if (cmd.apply) begin
      case (r_op)
        OP_UPSERT: begin
          if (r_st >= ST_OFFLINE) begin
            if (hit_f) used[hit_i] <= 1'b0;
          end else if (hit_f) begin
            if (sst[hit_i] != r_st) begin
              sst[hit_i] <= r_st; stime[hit_i] <= r_now;
            end
          end else if (ins) begin
            used[ins_i] <= 1'b1; skey[ins_i] <= r_key; sst[ins_i] <= r_st;
            stime[ins_i] <= r_now; sacc[ins_i] <= 1'b0; shue[ins_i] <= '0;
            sprog[ins_i] <= '0;
          end
        end
        OP_REMOVE: if (hit_f) used[hit_i] <= 1'b0;
        OP_CLEAR: used <= '0;
        OP_ACCENT: if (hit_f) begin
          shue[hit_i] <= r_val; sacc[hit_i] <= 1'b1;
        end
        OP_PROGRESS: if (hit_f)
          sprog[hit_i] <= (r_val > 8'(PROG_MAX)) ? PROG_MAX : r_val[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      chosen_v <= (r_op == OP_UPSERT) && r_st < ST_OFFLINE && (hit_f || ins);
      chosen <= hit_f ? hit_i : ins_i;
    end
  end

  // used count and top status over live table, cheap at this size
  always_comb begin
    cnt = '0;
    top_f = 1'b0; top_i = '0; top_p = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (used[i]) begin
        cnt = cnt + 1'b1;
        if (!top_f || prio(sst[i]) > top_p) begin
          top_f = 1'b1; top_i = IW'(i); top_p = prio(sst[i]);
        end
      end
    end
  end

  // next used slot at or after eidx
  logic nx_f;
  logic [IW-1:0] nx_i;
  logic nx2_f;
  always_comb begin
    nx_f = 1'b0; nx_i = '0; nx2_f = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (used[i] && CW'(i) >= eidx) begin
        if (nx_f) nx2_f = 1'b1;
        else begin
          nx_f = 1'b1; nx_i = IW'(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      eidx <= '0; ecnt <= '0;
    end else if (cmd.emit_next) begin
      eidx <= CW'(nx_i) + 1'b1; ecnt <= ecnt + 1'b1;
    end
  end

  logic snap_e;
  assign snap_e = (r_op == OP_SNAPSHOT) && nx_f && ecnt < r_lim;
  assign last = !snap_e || !nx2_f || (ecnt + 4'd1 >= r_lim);
  assign sts.emit_done = last;

  always_comb begin
    used_count = 4'(cnt);
    top_status = top_f ? sst[top_i] : ST_OFFLINE;
    if (snap_e) begin
      slot = 3'(nx_i); slot_valid = 1'b1;
      entry_key = skey[nx_i]; entry_status = sst[nx_i]; entry_time = stime[nx_i];
      entry_has_accent = sacc[nx_i]; entry_hue = shue[nx_i];
      entry_progress = sprog[nx_i];
    end else begin
      slot = chosen_v ? 3'(chosen) : 3'd0; slot_valid = chosen_v;
      entry_key = '0; entry_status = '0; entry_time = '0;
      entry_has_accent = 1'b0; entry_hue = '0; entry_progress = '0;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(SLOTS)) else $error("count out of range");
  a_hit_used: assert property (@(posedge clk) disable iff (rst)
    (cmd.apply && hit_f) |-> used[hit_i]) else $error("hit on free slot");
  a_snap_used: assert property (@(posedge clk) disable iff (rst)
    snap_e |-> used[nx_i]) else $error("snapshot of free slot");

endmodule

// File: tb/sv/priority_session_slot_table_tb.sv
`timescale 1ns / 1ps

module priority_session_slot_table_tb;
  import psst_pkg::*;

  typedef struct {
    logic [2:0]  slot;
    logic        slot_valid;
    logic [3:0]  used_count;
    logic [2:0]  top_status;
    logic [31:0] entry_key;
    logic [2:0]  entry_status;
    logic [31:0] entry_time;
    logic        entry_has_accent;
    logic [7:0]  entry_hue;
    logic [6:0]  entry_progress;
    logic        last;
  } session_result_t;

  class session_table_scoreboard;
    bit          used [8];
    logic [31:0] skey [8];
    logic [2:0]  sstat [8];
    logic [31:0] stime [8];
    bit          accent [8];
    logic [7:0]  hue [8];
    logic [6:0]  prog [8];
    session_result_t pending [$];
    int errors;

    function void wipe_slot(int i);
      used[i] = 0; skey[i] = 0; sstat[i] = 0; stime[i] = 0;
      accent[i] = 0; hue[i] = 0; prog[i] = 0;
    endfunction

    function void wipe_all();
      for (int i = 0; i < 8; i++) wipe_slot(i);
    endfunction

    function int rank(logic [2:0] s);
      case (s)
        3'd3: return 4;
        3'd2: return 3;
        3'd5: return 2;
        3'd1, 3'd4: return 1;
        default: return 0;
      endcase
    endfunction

    function int lookup(logic [31:0] k);
      for (int i = 0; i < 8; i++) if (used[i] && skey[i] == k) return i;
      return -1;
    endfunction

    function int place(logic [31:0] k, logic [2:0] st, logic [31:0] t);
      int i;
      int victim;
      int vp;
      i = lookup(k);
      victim = -1;
      vp = 0;
      if (st >= ST_OFFLINE) begin
        if (i >= 0) wipe_slot(i);
        return -1;
      end
      if (i >= 0) begin
        if (sstat[i] != st) begin
          sstat[i] = st;
          stime[i] = t;
        end
        return i;
      end
      for (i = 0; i < 8; i++) if (!used[i]) break;
      if (i >= 8) begin
        for (int j = 0; j < 8; j++)
          if (victim < 0 || rank(sstat[j]) < vp) begin
            victim = j;
            vp = rank(sstat[j]);
          end
        if (rank(st) <= vp) return -1;
        i = victim;
      end
      used[i] = 1; skey[i] = k; sstat[i] = st; stime[i] = t;
      accent[i] = 0; hue[i] = 0; prog[i] = 0;
      return i;
    endfunction

    function void note_request(logic [2:0] op, logic [31:0] k, logic [2:0] st,
                               logic [31:0] t, logic [7:0] v, logic [3:0] lim);
      int chosen;
      int i;
      int cnt;
      int best;
      int bp;
      int n;
      int maxn;
      logic [2:0] top;
      session_result_t r;
      chosen = -1;
      case (op)
        OP_UPSERT: chosen = place(k, st, t);
        OP_REMOVE: begin
          i = lookup(k);
          if (i >= 0) wipe_slot(i);
        end
        OP_CLEAR: wipe_all();
        OP_ACCENT: begin
          i = lookup(k);
          if (i >= 0) begin
            hue[i] = v;
            accent[i] = 1;
          end
        end
        OP_PROGRESS: begin
          i = lookup(k);
          if (i >= 0) prog[i] = (v > PROG_MAX) ? PROG_MAX : v[6:0];
        end
        default: ;
      endcase
      cnt = 0;
      best = -1;
      bp = 0;
      for (int j = 0; j < 8; j++) if (used[j]) begin
        cnt++;
        if (best < 0 || rank(sstat[j]) > bp) begin
          best = j;
          bp = rank(sstat[j]);
        end
      end
      top = (best < 0) ? ST_OFFLINE : sstat[best];
      maxn = (lim > MAX_RES) ? MAX_RES : lim;
      n = 0;
      if (op == OP_SNAPSHOT) begin
        for (int j = 0; j < 8 && n < maxn; j++) if (used[j]) begin
          r.slot = j[2:0]; r.slot_valid = 1; r.used_count = cnt[3:0];
          r.top_status = top; r.entry_key = skey[j]; r.entry_status = sstat[j];
          r.entry_time = stime[j]; r.entry_has_accent = accent[j];
          r.entry_hue = hue[j]; r.entry_progress = prog[j]; r.last = 0;
          pending.push_back(r);
          n++;
        end
        if (n > 0) begin
          pending[$].last = 1;
          return;
        end
      end
      r = '{default: 0};
      if (chosen >= 0) begin
        r.slot = chosen[2:0];
        r.slot_valid = 1;
      end
      r.used_count = cnt[3:0];
      r.top_status = top;
      r.last = 1;
      pending.push_back(r);
    endfunction

    function void check_result(session_result_t a);
      session_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result slot=%0d", a.slot);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.slot !== e.slot) begin
        $error("slot exp %0d got %0d", e.slot, a.slot); errors++;
      end
      if (a.slot_valid !== e.slot_valid) begin
        $error("slot_valid exp %0d got %0d", e.slot_valid, a.slot_valid); errors++;
      end
      if (a.used_count !== e.used_count) begin
        $error("used_count exp %0d got %0d", e.used_count, a.used_count); errors++;
      end
      if (a.top_status !== e.top_status) begin
        $error("top_status exp %0d got %0d", e.top_status, a.top_status); errors++;
      end
      if (a.entry_key !== e.entry_key) begin
        $error("entry_key exp %0h got %0h", e.entry_key, a.entry_key); errors++;
      end
      if (a.entry_status !== e.entry_status) begin
        $error("entry_status exp %0d got %0d", e.entry_status, a.entry_status); errors++;
      end
      if (a.entry_time !== e.entry_time) begin
        $error("entry_time exp %0h got %0h", e.entry_time, a.entry_time); errors++;
      end
      if (a.entry_has_accent !== e.entry_has_accent) begin
        $error("entry_has_accent exp %0d got %0d", e.entry_has_accent,
               a.entry_has_accent);
        errors++;
      end
      if (a.entry_hue !== e.entry_hue) begin
        $error("entry_hue exp %0d got %0d", e.entry_hue, a.entry_hue); errors++;
      end
      if (a.entry_progress !== e.entry_progress) begin
        $error("entry_progress exp %0d got %0d", e.entry_progress, a.entry_progress);
        errors++;
      end
      if (a.last !== e.last) begin
        $error("last exp %0d got %0d", e.last, a.last); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [2:0]  operation = 0;
  logic [31:0] key = 0;
  logic [2:0]  status = 0;
  logic [31:0] now_ms = 0;
  logic [7:0]  value = 0;
  logic [3:0]  limit = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [2:0]  slot;
  logic        slot_valid;
  logic [3:0]  used_count;
  logic [2:0]  top_status;
  logic [31:0] entry_key;
  logic [2:0]  entry_status;
  logic [31:0] entry_time;
  logic        entry_has_accent;
  logic [7:0]  entry_hue;
  logic [6:0]  entry_progress;
  logic        last;

  int send_idle = 0;
  int recv_stall = 0;
  int phase_no = 0;
  logic [31:0] key_pool [6];
  session_table_scoreboard table_sb = new();

  priority_session_slot_table dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        table_sb.check_result('{slot, slot_valid, used_count, top_status, entry_key,
                                entry_status, entry_time, entry_has_accent, entry_hue,
                                entry_progress, last});
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic send_request(logic [2:0] op, logic [31:0] k, logic [2:0] st,
                              logic [31:0] t, logic [7:0] v, logic [3:0] lim);
    while ($urandom_range(99) < send_idle) begin
      if (in_valid) in_valid <= 0;
      @(posedge clk);
    end
    operation <= op; key <= k; status <= st; now_ms <= t; value <= v; limit <= lim;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    table_sb.note_request(op, k, st, t, v, lim);
  endtask

  task automatic send_random();
    logic [2:0] op;
    logic [31:0] k;
    int r;
    r = $urandom_range(99);
    op = (r < 45) ? OP_UPSERT : (r < 53) ? OP_REMOVE : (r < 55) ? OP_CLEAR :
         (r < 65) ? OP_ACCENT : (r < 75) ? OP_PROGRESS : (r < 97) ? OP_SNAPSHOT :
         3'($urandom_range(7, 6));
    k = ($urandom_range(9) < 8) ? key_pool[$urandom_range(5) + (phase_no % 2) * 0]
                                : $urandom;
    if ($urandom_range(3) == 0) k = key_pool[0] + $urandom_range(10);
    send_request(op, k, 3'($urandom_range(7)), $urandom, 8'($urandom),
                 4'($urandom_range(15)));
  endtask

  initial begin
    for (int i = 0; i < 6; i++) key_pool[i] = $urandom;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: fill table, eviction, refusal, special statuses
    send_request(OP_SNAPSHOT, 0, 0, 0, 0, 4'd8);
    for (int i = 0; i < 8; i++)
      send_request(OP_UPSERT, 32'hFFFF_FFF0 + i, 3'(i % 2 ? 4 : 0), i, 0, 0);
    send_request(OP_UPSERT, 32'h0, 3'd0, 32'hFFFF_FFFF, 0, 0);
    send_request(OP_UPSERT, 32'h0, 3'd3, 32'hFFFF_FFFF, 0, 0);
    send_request(OP_UPSERT, 32'h0, 3'd3, 32'h1234, 0, 0);
    send_request(OP_ACCENT, 32'h0, 0, 0, 8'hFF, 0);
    send_request(OP_PROGRESS, 32'h0, 0, 0, 8'd255, 0);
    send_request(OP_PROGRESS, 32'hFFFF_FFF1, 0, 0, 8'd100, 0);
    send_request(OP_PROGRESS, 32'h5555_5555, 0, 0, 8'd7, 0);
    send_request(OP_SNAPSHOT, 0, 0, 0, 0, 4'd15);
    send_request(OP_SNAPSHOT, 0, 0, 0, 0, 4'd3);
    send_request(OP_UPSERT, 32'hFFFF_FFF1, 3'd6, 0, 0, 0);
    send_request(OP_UPSERT, 32'hFFFF_FFF3, 3'd7, 0, 0, 0);
    send_request(OP_REMOVE, 32'hFFFF_FFF5, 0, 0, 0, 0);
    send_request(3'd6, 0, 0, 0, 0, 0);
    send_request(3'd7, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF, 8'hFF, 4'hF);
    send_request(OP_SNAPSHOT, 0, 0, 0, 0, 4'd0);
    send_request(OP_CLEAR, 0, 0, 0, 0, 0);
    send_request(OP_SNAPSHOT, 0, 0, 0, 0, 4'd8);
    for (phase_no = 0; phase_no < 5; phase_no++) begin
      case (phase_no)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 49; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 49; end
        3: begin send_idle = 16; recv_stall = 16; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      repeat (100) send_random();
    end
    in_valid <= 0;
    while (table_sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (table_sb.errors == 0) $display("priority_session_slot_table test passed");
    else $display("priority_session_slot_table test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("priority_session_slot_table test failed");
    $finish;
  end

endmodule

// File: files.f
rtl/core/psst_pkg.sv
rtl/core/psst_ctrl.sv
rtl/core/psst_dp.sv
rtl/core/priority_session_slot_table.sv
tb/sv/priority_session_slot_table_tb.sv
